>>> design/cwc_pkg.sv
`timescale 1ns / 1ps

package cwc_pkg;

  // saturation limit of the emitted byte count
  localparam longint unsigned LENGTH_MAX_DEF = 64'd65535;
  // bursts buffered between classifier and serializer
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4,
    MODE_STRING = 3'd5
  } scan_mode_e;

  // results caused by one text byte: n_bytes characters, then the terminator if term
  typedef struct packed {
    logic [1:0]      n_bytes;
    logic [2:0][7:0] bytes;
    logic            term;
    logic [15:0]     length;
  } burst_t;

endpackage

>>> design/cwc_front.sv
`timescale 1ns / 1ps

module cwc_front import cwc_pkg::*; #(
  parameter longint unsigned LENGTH_MAX = LENGTH_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_input_i,
  output logic       push_o,
  output burst_t     burst_o
);

  localparam int unsigned CNT_W = $clog2(64'(LENGTH_MAX) + 64'd1);

  scan_mode_e       mode_q, mode_d;
  logic             pnl_q, pnl_d;
  logic             psp_q, psp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [1:0]       nb;
  logic [2:0][7:0]  b;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] cnt_sat;
  logic [7:0]       c;

  assign c = text_byte_i;

  always_comb begin
    mode_d = mode_q;
    pnl_d  = pnl_q;
    psp_d  = psp_q;
    nb     = 2'd0;
    b      = '0;

    if (c != CH_NUL) begin
      case (mode_q)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_d = MODE_LINE;
          end else if (c == CH_STAR) begin
            mode_d = MODE_BSTAR;
          end else begin
            mode_d = MODE_NORMAL;
            // held slash goes out as a token
            if (pnl_q) begin
              b[nb] = CH_LF;
              nb = nb + 2'd1;
            end else if (psp_q) begin
              b[nb] = CH_SPACE;
              nb = nb + 2'd1;
            end
            pnl_d = 1'b0;
            psp_d = 1'b0;
            b[nb] = CH_SLASH;
            nb = nb + 2'd1;
            if (c == CH_LF || c == CH_CR) begin
              pnl_d = 1'b1;
            end else if (c == CH_SPACE || c == CH_TAB) begin
              psp_d = 1'b1;
            end else begin
              b[nb] = c;
              nb = nb + 2'd1;
              if (c == CH_QUOTE) mode_d = MODE_STRING;
            end
          end
        end
        MODE_LINE: begin
          if (c == CH_LF) begin
            mode_d = MODE_NORMAL;
            pnl_d  = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) mode_d = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (c == CH_SLASH) mode_d = MODE_NORMAL;
          else if (c != CH_STAR) mode_d = MODE_BLOCK;
        end
        MODE_STRING: begin
          b[nb] = c;
          nb = nb + 2'd1;
          if (c == CH_QUOTE) mode_d = MODE_NORMAL;
        end
        default: begin
          mode_d = MODE_NORMAL;
          if (c == CH_SLASH) begin
            mode_d = MODE_SLASH;
          end else if (c == CH_LF || c == CH_CR) begin
            pnl_d = 1'b1;
          end else if (c == CH_SPACE || c == CH_TAB) begin
            psp_d = 1'b1;
          end else begin
            if (pnl_q) begin
              b[nb] = CH_LF;
              nb = nb + 2'd1;
            end else if (psp_q) begin
              b[nb] = CH_SPACE;
              nb = nb + 2'd1;
            end
            pnl_d = 1'b0;
            psp_d = 1'b0;
            b[nb] = c;
            nb = nb + 2'd1;
            if (c == CH_QUOTE) mode_d = MODE_STRING;
          end
        end
      endcase
    end

    // end of text flushes a held slash
    if (end_of_input_i && mode_d == MODE_SLASH) begin
      if (pnl_d) begin
        b[nb] = CH_LF;
        nb = nb + 2'd1;
      end else if (psp_d) begin
        b[nb] = CH_SPACE;
        nb = nb + 2'd1;
      end
      b[nb] = CH_SLASH;
      nb = nb + 2'd1;
    end

    sum = {1'b0, cnt_q} + (CNT_W+1)'(nb);
    if (sum > (CNT_W+1)'(LENGTH_MAX)) cnt_sat = CNT_W'(LENGTH_MAX);
    else cnt_sat = sum[CNT_W-1:0];
    cnt_d = cnt_sat;

    if (end_of_input_i) begin
      mode_d = MODE_NORMAL;
      pnl_d  = 1'b0;
      psp_d  = 1'b0;
      cnt_d  = '0;
    end
  end

  always_comb begin
    burst_o.n_bytes = nb;
    burst_o.bytes   = b;
    burst_o.term    = end_of_input_i;
    burst_o.length  = (64'(cnt_sat) > 64'd65535) ? 16'hFFFF : 16'(cnt_sat);
    push_o          = accept_i && (nb != 2'd0 || end_of_input_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      pnl_q  <= 1'b0;
      psp_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pnl_q  <= pnl_d;
      psp_q  <= psp_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> design/cwc_queue.sv
`timescale 1ns / 1ps

module cwc_queue import cwc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  burst_t burst_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output burst_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  burst_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= burst_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

>>> design/cwc_back.sv
`timescale 1ns / 1ps

module cwc_back import cwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  burst_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        terminator_o,
  output logic [15:0] total_length_o
);

  logic [1:0] idx_q, idx_d;
  logic [2:0] total;
  logic [1:0] sel;
  logic       is_term, xfer;

  assign total   = {1'b0, head_i.n_bytes} + {2'b00, head_i.term};
  assign is_term = (idx_q >= head_i.n_bytes);
  assign sel     = is_term ? 2'd0 : idx_q;
  assign xfer    = out_valid_o && out_ready_i;

  assign out_valid_o    = head_valid_i;
  assign out_byte_o     = is_term ? CH_NUL : head_i.bytes[sel];
  assign terminator_o   = is_term;
  assign total_length_o = is_term ? head_i.length : 16'd0;
  assign run_last_o     = ({1'b0, idx_q} == total - 3'd1);
  assign pop_o          = xfer && run_last_o;

  always_comb begin
    idx_d = idx_q;
    if (xfer) idx_d = run_last_o ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else idx_q <= idx_d;
  end

endmodule

>>> design/comment_whitespace_compactor_core.sv
`timescale 1ns / 1ps

// comment and whitespace compactor
// slave stream: one text byte per beat, tlast marks the final byte of a text
// master stream: one compacted character per beat; tlast marks the last beat
//   caused by one input byte, tuser marks the closing zero terminator, which
//   carries the saturated count of emitted bytes in tdata[23:8]
// the front classifies each byte against the scan state and writes the whole
// burst (up to three characters plus the terminator) into a queue, four deep by default;
// the back serializes the queue head one result per beat
// throughput: one input byte per cycle while the queue has room; the output
//   side moves one result per cycle while the receiver is ready, so the back
//   stays on a burst until its last result is taken, at the output port rate
// each accepted burst is registered in the queue before the back sends it
// reset: scan state back to normal text, pending blank and line break and the
//   emitted count cleared, queue empty; each terminator clears all but the queue
// stall: a stalled receiver holds the current beat, the queue fills and then
//   s_axis_tready drops until the back drains an entry
module comment_whitespace_compactor_core import cwc_pkg::*; #(
  parameter longint unsigned LENGTH_MAX  = LENGTH_MAX_DEF,
  parameter int unsigned     QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte [7:0]
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_byte [7:0], total_length [23:8]
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // terminator
);

  logic        accept;
  logic        push, full, head_valid, pop;
  burst_t      burst, head;
  logic [7:0]  out_byte;
  logic [15:0] total_length;

  // ready does not look at the payload, only at queue room
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cwc_front #(
    .LENGTH_MAX(LENGTH_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (s_axis_tdata),
    .end_of_input_i(s_axis_tlast),
    .push_o        (push),
    .burst_o       (burst)
  );

  cwc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .burst_i(burst),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .head_o (head)
  );

  cwc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (out_byte),
    .run_last_o    (m_axis_tlast),
    .terminator_o  (m_axis_tuser),
    .total_length_o(total_length)
  );

  assign m_axis_tdata = {total_length, out_byte};

  // the terminator always closes the run of its input byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("terminator beat without tlast");

  // the terminator carries a zero character
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == CH_NUL))
    else $error("terminator beat with nonzero character");

  // ordinary characters report no length and are never zero
  a_char_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[23:8] == 16'd0 && m_axis_tdata[7:0] != CH_NUL))
    else $error("character beat with length or zero character");

endmodule

>>> tb/cwc_output_checker.sv
`timescale 1ns / 1ps

module cwc_output_checker import cwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte [7:0]
  input  logic        s_axis_tlast_i,   // end_of_input
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,   // out_byte [7:0], total_length [23:8]
  input  logic        m_axis_tlast_i,   // run_last
  input  logic        m_axis_tuser_i,   // terminator
  output int          errors_o,
  output int          pending_o,
  output int          beats_o,
  output int          texts_o
);

  typedef struct packed {
    logic [7:0]  ch;
    logic        run_last;
    logic        term;
    logic [15:0] total;
  } char_beat_t;

  char_beat_t  expected_chars_q[$];
  logic [7:0]  burst_q[$];

  // predicted scanner state
  scan_mode_e  mode;
  logic        nl_pending;
  logic        sp_pending;
  int unsigned char_count;

  int mismatches;
  int beats_checked;
  int texts_closed;

  function automatic void clear_scan();
    mode       = MODE_NORMAL;
    nl_pending = 1'b0;
    sp_pending = 1'b0;
    char_count = 0;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    burst_q.push_back(c);
    if (char_count < LENGTH_MAX_DEF) char_count++;
  endfunction

  // a token flushes the pending separator first, newline wins over space
  function automatic void emit_token(input logic [7:0] c);
    if (nl_pending) put_char(CH_LF);
    else if (sp_pending) put_char(CH_SPACE);
    nl_pending = 1'b0;
    sp_pending = 1'b0;
    put_char(c);
    if (c == CH_QUOTE) mode = MODE_STRING;
  endfunction

  function automatic void classify_plain(input logic [7:0] c);
    if (c == CH_SLASH) mode = MODE_SLASH;
    else if (c == CH_LF || c == CH_CR) nl_pending = 1'b1;
    else if (c == CH_SPACE || c == CH_TAB) sp_pending = 1'b1;
    else emit_token(c);
  endfunction

  function automatic void compact_text_byte(input logic [7:0] c, input logic eot);
    int         first;
    char_beat_t b;
    first = expected_chars_q.size();
    burst_q.delete();
    if (c != CH_NUL) begin
      case (mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) mode = MODE_LINE;
          else if (c == CH_STAR) mode = MODE_BSTAR;
          else begin
            mode = MODE_NORMAL;
            emit_token(CH_SLASH);
            classify_plain(c);
          end
        end
        MODE_LINE: begin
          if (c == CH_LF) begin
            mode       = MODE_NORMAL;
            nl_pending = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) mode = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (c == CH_SLASH) mode = MODE_NORMAL;
          else if (c != CH_STAR) mode = MODE_BLOCK;
        end
        MODE_STRING: begin
          put_char(c);
          if (c == CH_QUOTE) mode = MODE_NORMAL;
        end
        default: begin
          mode = MODE_NORMAL;
          classify_plain(c);
        end
      endcase
    end
    // a slash held at the end of the text goes out as a plain token
    if (eot && mode == MODE_SLASH) emit_token(CH_SLASH);
    foreach (burst_q[k]) begin
      b = '{ch: burst_q[k], run_last: 1'b0, term: 1'b0, total: 16'd0};
      expected_chars_q.push_back(b);
    end
    if (eot) begin
      b = '{ch: CH_NUL, run_last: 1'b0, term: 1'b1,
            total: (char_count > 32'hFFFF) ? 16'hFFFF : char_count[15:0]};
      expected_chars_q.push_back(b);
      clear_scan();
    end
    if (expected_chars_q.size() > first)
      expected_chars_q[expected_chars_q.size() - 1].run_last = 1'b1;
  endfunction

  function automatic void check_char_beat(input char_beat_t got);
    char_beat_t want;
    if (expected_chars_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: byte %02h last %0b term %0b length %0d",
                 got.ch, got.run_last, got.term, got.total);
      return;
    end
    want = expected_chars_q.pop_front();
    beats_checked++;
    if (want.term) texts_closed++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected byte %02h last %0b term %0b length %0d, got byte %02h last %0b term %0b length %0d",
                 want.ch, want.run_last, want.term, want.total,
                 got.ch, got.run_last, got.term, got.total);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_chars_q.delete();
      mismatches    = 0;
      beats_checked = 0;
      texts_closed  = 0;
      errors_o  <= 0;
      pending_o <= 0;
      beats_o   <= 0;
      texts_o   <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        compact_text_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i)
        check_char_beat('{ch: m_axis_tdata_i[7:0], run_last: m_axis_tlast_i,
                          term: m_axis_tuser_i, total: m_axis_tdata_i[23:8]});
      errors_o  <= mismatches;
      pending_o <= expected_chars_q.size();
      beats_o   <= beats_checked;
      texts_o   <= texts_closed;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cwc_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // text_byte [7:0]
  logic        s_axis_tlast  = 1'b0;   // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // out_byte [7:0], total_length [23:8]
  logic        m_axis_tlast;           // run_last
  logic        m_axis_tuser;           // terminator

  int errors;
  int pending;
  int beats;
  int texts;

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int cycle_count  = 0;
  int bytes_sent   = 0;

  logic [7:0] text_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  comment_whitespace_compactor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  cwc_output_checker output_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .m_axis_tuser_i  (m_axis_tuser),
    .errors_o        (errors),
    .pending_o       (pending),
    .beats_o         (beats),
    .texts_o         (texts)
  );

  // receiver stalls at the current idle rate
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic eot);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // sends the built text, end mark on its final byte
  task automatic send_text();
    foreach (text_q[k]) send_beat(text_q[k], k == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void add_str(input string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endfunction

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_SLASH || c == CH_QUOTE || c == CH_SPACE || c == CH_TAB ||
           c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // comment bodies lean toward stars and slashes to hit the closing logic
  function automatic logic [7:0] comment_char();
    case ($urandom_range(0, 3))
      0:       return CH_STAR;
      1:       return CH_SLASH;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void add_piece();
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 4)) text_q.push_back(token_char());
      3: repeat ($urandom_range(1, 3)) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      4: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       text_q.push_back(CH_LF);
            1:       text_q.push_back(CH_CR);
            default: text_q.push_back(CH_SPACE);
          endcase
        end
      end
      5: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_SLASH);
        repeat ($urandom_range(0, 4)) text_q.push_back(comment_char());
        if ($urandom_range(0, 4) != 0) text_q.push_back(CH_LF);
      end
      6: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(CH_SLASH);
        end else begin
          repeat ($urandom_range(0, 4)) text_q.push_back(comment_char());
          repeat ($urandom_range(1, 2)) text_q.push_back(CH_STAR);
          if ($urandom_range(0, 5) != 0) text_q.push_back(CH_SLASH);
        end
      end
      7: begin
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 4) != 0) text_q.push_back(CH_QUOTE);
      end
      8: begin
        // lone slash, so the held slash comes out in front of the next byte
        text_q.push_back(CH_SLASH);
        case ($urandom_range(0, 2))
          0:       text_q.push_back(CH_QUOTE);
          1:       text_q.push_back(CH_SPACE);
          default: text_q.push_back(token_char());
        endcase
      end
      default: text_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
    endcase
  endfunction

  // mostly well formed texts built from tokens, blanks, comments and strings
  task automatic run_random_texts(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      repeat ($urandom_range(1, 8)) add_piece();
      foreach (text_q[k]) if (text_q[k] != CH_NUL) sent++;
      send_text();
    end
  endtask

  // hold the sender until every predicted beat has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 25;
    dst_idle_pct = 71;

    // extremes, blank and line break runs, slash-star-slash comment,
    // pending space dropped at the end, zero byte carrying the end mark
    text_q.push_back(8'h01);
    add_str(" \t");
    text_q.push_back(CH_CR);
    text_q.push_back(8'hFF);
    add_str("/*/ ");
    text_q.push_back(CH_NUL);
    send_text();
    // slashes inside a string, line comment closed by a line feed only,
    // held slash flushed at the end behind a pending space
    add_str("\"//\"//");
    text_q.push_back(CH_CR);
    add_str("\nq /");
    send_text();
    // star runs inside a block comment left open at the end
    add_str("/***x");
    send_text();

    run_random_texts(118);
    wait_drained();

    src_idle_pct = 71;
    dst_idle_pct = 25;
    run_random_texts(118);
    wait_drained();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random_texts(118);

    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("covered %0d text bytes in %0d texts, %0d result beats checked",
             bytes_sent, texts, beats);
    $display("includes comments, strings, blank runs, held slashes and zero bytes under stalls");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
